@@ src/poct_pkg.sv @@
package poct_pkg;

    localparam logic [1:0] ACT_CLAIM   = 2'd0;
    localparam logic [1:0] ACT_QUERY   = 2'd1;
    localparam logic [1:0] ACT_RESOLVE = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [2:0] ST_NEW            = 3'd0;
    localparam logic [2:0] ST_SHARED         = 3'd1;
    localparam logic [2:0] ST_REJECT         = 3'd2;
    localparam logic [2:0] ST_FATAL_CONFLICT = 3'd3;
    localparam logic [2:0] ST_FATAL_FULL     = 3'd4;
    localparam logic [2:0] ST_SKIPPED        = 3'd5;
    localparam logic [2:0] ST_HALTED         = 3'd6;
    localparam logic [2:0] ST_DONE           = 3'd7;

    localparam logic [7:0] PIN_EMPTY     = 8'd255;
    localparam logic [7:0] BATCH_MAX     = 8'd255;
    localparam logic [5:0] LIMIT_RESET   = 6'd32;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] pin;
        logic [4:0] owner;
        logic       critical;
        logic       shared;
        logic       batch_last;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] found_owner;
        logic [7:0] resolved_pin;
        logic [7:0] batch_granted;
        logic [5:0] fill_level;
    } rsp_t;

    typedef struct packed {
        logic [7:0] pin;
        logic [4:0] owner;
        logic       shared;
    } entry_t;

endpackage

@@ src/poct_ram.sv @@
module poct_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/pin_ownership_claim_table_core.sv @@
// Pin ownership claim table.
// Requests enter on s_valid/s_ready with a poct_pkg::req_t payload (claim,
// owner query, resolve for owner, clear). Each request yields exactly one
// response on m_valid/m_ready with a poct_pkg::rsp_t payload. The usable
// table size is written through cfg_valid/cfg_ready/cfg_data (always ready);
// write it only while no request is in flight.
// Scan: a claim, query or resolve scans the recorded entries through the
// entry RAM, one entry per cycle, stopping at the first hit. Each entry is
// compared once its registered RAM read returns; the result then waits in
// S_PUSH until the output register is free. Skipped claims, clears and
// requests seen while halted skip the scan and go straight to S_PUSH. One
// request is worked on at a time; the next is taken once the previous
// response sits in the output register.
// Reset (aresetn low, synchronous) empties the table, clears the halt flag
// and the batch count, and sets the limit to 32. The RAM contents are not
// cleared; only entries below the fill count are ever compared.
// A stalled receiver holds the response in the output register; one further
// response may be finished and parked before s_ready stays low.
module pin_ownership_claim_table_core #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic           aclk,
    input  logic           aresetn,

    input  logic           s_valid,
    output logic           s_ready,
    input  poct_pkg::req_t s_data,

    output logic           m_valid,
    input  logic           m_ready,
    output poct_pkg::rsp_t m_data,

    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [5:0]     cfg_data
);

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
    localparam int EW    = $bits(poct_pkg::entry_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PUSH
    } state_t;

    state_t           state_reg, state_next;
    poct_pkg::req_t   req_reg, req_next;
    poct_pkg::rsp_t   res_reg, res_next;
    poct_pkg::rsp_t   m_data_reg, m_data_next;
    logic             m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             halted_reg, halted_next;
    logic [7:0]       batch_reg, batch_next;
    logic [5:0]       limit_reg, limit_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_wdata;
    logic [EW-1:0]    ram_rdata;
    poct_pkg::entry_t entry;
    poct_pkg::entry_t new_entry;

    logic             hit;
    logic             table_full;
    logic             granted;
    logic [7:0]       batch_upd;

    poct_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    assign entry     = poct_pkg::entry_t'(ram_rdata);
    assign new_entry = '{pin: req_reg.pin, owner: req_reg.owner, shared: req_reg.shared};
    assign ram_wdata = new_entry;
    assign ram_waddr = fill_reg[AW-1:0];
    assign ram_raddr = idx_reg[AW-1:0];

    // Compare the entry returned for the previous read; resolve also needs the owner.
    assign hit = rd_pend_reg && (entry.pin == req_reg.pin) &&
                 ((req_reg.action != poct_pkg::ACT_RESOLVE) || (entry.owner == req_reg.owner));

    // Full when at the configured limit or at the physical depth.
    assign table_full = (CMP_W'(fill_reg) >= CMP_W'(limit_reg)) ||
                        (fill_reg >= CNT_W'(MAX_ENTRIES));

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        idx_next     = idx_reg;
        rd_pend_next = rd_pend_reg;
        fill_next    = fill_reg;
        halted_next  = halted_reg;
        batch_next   = batch_reg;
        limit_next   = limit_reg;
        ram_we       = 1'b0;
        granted      = 1'b0;
        batch_upd    = batch_reg;

        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end

        // Drop the response once taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next               = s_data;
                    res_next.status        = poct_pkg::ST_DONE;
                    res_next.found_owner   = '0;
                    res_next.resolved_pin  = poct_pkg::PIN_EMPTY;
                    res_next.batch_granted = batch_reg;
                    res_next.fill_level    = '0;
                    idx_next               = '0;
                    rd_pend_next           = 1'b0;
                    state_next             = S_PUSH;
                    if (halted_reg) begin
                        res_next.status = poct_pkg::ST_HALTED;
                    end else begin
                        case (s_data.action)
                            poct_pkg::ACT_CLAIM: begin
                                if (s_data.pin == poct_pkg::PIN_EMPTY) begin
                                    res_next.status = poct_pkg::ST_SKIPPED;
                                    if (s_data.batch_last) begin
                                        batch_next = '0;
                                    end
                                end else begin
                                    state_next = S_SCAN;
                                end
                            end
                            poct_pkg::ACT_QUERY, poct_pkg::ACT_RESOLVE: begin
                                state_next = S_SCAN;
                            end
                            poct_pkg::ACT_CLEAR: begin
                                fill_next = '0;
                            end
                            default: begin
                                state_next = S_PUSH;
                            end
                        endcase
                    end
                end
            end

            S_SCAN: begin
                if (!hit && (idx_reg < fill_reg)) begin
                    // Advance: issue the next read.
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    state_next   = S_PUSH;
                    case (req_reg.action)
                        poct_pkg::ACT_CLAIM: begin
                            if (hit) begin
                                if ((entry.owner == req_reg.owner) && entry.shared &&
                                    req_reg.shared) begin
                                    res_next.status = poct_pkg::ST_SHARED;
                                    granted         = 1'b1;
                                end else if (req_reg.critical) begin
                                    res_next.status = poct_pkg::ST_FATAL_CONFLICT;
                                    halted_next     = 1'b1;
                                end else begin
                                    res_next.status = poct_pkg::ST_REJECT;
                                end
                            end else if (table_full) begin
                                res_next.status = poct_pkg::ST_FATAL_FULL;
                                halted_next     = 1'b1;
                            end else begin
                                ram_we          = 1'b1;
                                fill_next       = fill_reg + 1'b1;
                                res_next.status = poct_pkg::ST_NEW;
                                granted         = 1'b1;
                            end
                            if (granted && (batch_reg != poct_pkg::BATCH_MAX)) begin
                                batch_upd = batch_reg + 8'd1;
                            end
                            res_next.batch_granted = batch_upd;
                            batch_next = req_reg.batch_last ? '0 : batch_upd;
                        end
                        poct_pkg::ACT_QUERY: begin
                            if (hit) begin
                                res_next.found_owner = entry.owner;
                            end
                        end
                        poct_pkg::ACT_RESOLVE: begin
                            if (hit) begin
                                res_next.resolved_pin = req_reg.pin;
                            end
                        end
                        default: begin
                            state_next = S_PUSH;
                        end
                    endcase
                end
            end

            S_PUSH: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_data_next            = res_reg;
                    m_data_next.fill_level = 6'(fill_reg);
                    m_valid_next           = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            idx_reg     <= '0;
            fill_reg    <= '0;
            halted_reg  <= 1'b0;
            batch_reg   <= '0;
            limit_reg   <= poct_pkg::LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rd_pend_reg <= rd_pend_next;
            idx_reg     <= idx_next;
            fill_reg    <= fill_next;
            halted_reg  <= halted_next;
            batch_reg   <= batch_next;
            limit_reg   <= limit_next;
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // The table never records more entries than the RAM holds.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond table depth");

    // An append only happens below the configured limit.
    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (CMP_W'(fill_reg) < CMP_W'(limit_reg)))
        else $error("append at or above table limit");

    // A fatal halt is sticky until reset.
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag released without reset");

    // The scan index never runs past the fill count.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (idx_reg <= fill_reg))
        else $error("scan index beyond fill count");

endmodule

@@ tb/sv/poct_claim_checker.sv @@
// Watches the request, response and limit channels of the claim table. It keeps
// its own copy of the table and queues one answer per accepted request.
module poct_claim_checker
    import poct_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  req_t       s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  rsp_t       m_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [5:0] cfg_data,
    output int         mismatches,
    output int         outstanding,
    output int         answered
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    entry_t     tbl [TABLE_DEPTH];
    logic [5:0] tbl_fill;
    logic       tbl_halted;
    logic [7:0] tbl_batch;
    logic [5:0] tbl_limit;
    rsp_t       answers_due [$];
    int         err_total = 0;
    int         rsp_total = 0;

    assign mismatches = err_total;
    assign answered   = rsp_total;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
        err_total++;
    endtask

    // Work one request against the table copy; return the response it owes.
    function automatic rsp_t apply_request(input req_t r);
        rsp_t       a;
        int         hit;
        logic [5:0] lim;
        logic       granted;
        a.status       = ST_DONE;
        a.found_owner  = '0;
        a.resolved_pin = PIN_EMPTY;
        granted        = 1'b0;
        lim            = (tbl_limit < 6'(TABLE_DEPTH)) ? tbl_limit : 6'(TABLE_DEPTH);
        hit            = -1;
        for (int i = 0; i < tbl_fill; i++) begin
            if (hit < 0 && tbl[i].pin == r.pin) hit = i;
        end
        if (tbl_halted) begin
            a.status = ST_HALTED;
        end else begin
            case (r.action)
                ACT_CLAIM: begin
                    if (r.pin == PIN_EMPTY) begin
                        a.status = ST_SKIPPED;
                    end else if (hit >= 0) begin
                        if (tbl[hit].owner == r.owner && tbl[hit].shared && r.shared) begin
                            a.status = ST_SHARED;
                            granted  = 1'b1;
                        end else if (r.critical) begin
                            a.status   = ST_FATAL_CONFLICT;
                            tbl_halted = 1'b1;
                        end else begin
                            a.status = ST_REJECT;
                        end
                    end else if (tbl_fill >= lim) begin
                        a.status   = ST_FATAL_FULL;
                        tbl_halted = 1'b1;
                    end else begin
                        tbl[tbl_fill[IW-1:0]] = '{pin: r.pin, owner: r.owner, shared: r.shared};
                        tbl_fill++;
                        a.status = ST_NEW;
                        granted  = 1'b1;
                    end
                    if (granted && tbl_batch != BATCH_MAX) tbl_batch++;
                end
                ACT_QUERY: begin
                    if (hit >= 0) a.found_owner = tbl[hit].owner;
                end
                ACT_RESOLVE: begin
                    for (int i = 0; i < tbl_fill; i++) begin
                        if (tbl[i].pin == r.pin && tbl[i].owner == r.owner) a.resolved_pin = r.pin;
                    end
                end
                default: begin
                    tbl_fill = '0;
                end
            endcase
        end
        a.batch_granted = tbl_batch;
        // the batch count is cleared only by a claim that was actually worked
        if (a.status != ST_HALTED && r.action == ACT_CLAIM && r.batch_last) tbl_batch = '0;
        a.fill_level = tbl_fill;
        return a;
    endfunction

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            tbl_fill   = '0;
            tbl_halted = 1'b0;
            tbl_batch  = '0;
            tbl_limit  = LIMIT_RESET;
            answers_due.delete();
        end else begin
            // pop before push: a response never belongs to a request taken at its own edge
            if (m_valid && m_ready) begin
                rsp_total++;
                if (answers_due.size() == 0) begin
                    report_mismatch("response with no request waiting", 32'(m_data), 32'd0);
                end else begin
                    want = answers_due.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", 32'(m_data.status), 32'(want.status));
                    if (m_data.found_owner !== want.found_owner)
                        report_mismatch("found_owner", 32'(m_data.found_owner),
                                        32'(want.found_owner));
                    if (m_data.resolved_pin !== want.resolved_pin)
                        report_mismatch("resolved_pin", 32'(m_data.resolved_pin),
                                        32'(want.resolved_pin));
                    if (m_data.batch_granted !== want.batch_granted)
                        report_mismatch("batch_granted", 32'(m_data.batch_granted),
                                        32'(want.batch_granted));
                    if (m_data.fill_level !== want.fill_level)
                        report_mismatch("fill_level", 32'(m_data.fill_level),
                                        32'(want.fill_level));
                end
            end
            if (cfg_valid && cfg_ready) tbl_limit = cfg_data;
            if (s_valid && s_ready) answers_due.push_back(apply_request(s_data));
        end
        outstanding <= answers_due.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// Top of the claim table bench: clock, reset, request and limit stimulus,
// receiver back-pressure and the verdict. All checking lives in the checker.
module tb;
    import poct_pkg::*;

    localparam int DEPTH = 32;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    req_t       s_data    = '0;
    logic       m_ready   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [5:0] cfg_data  = '0;
    logic       s_ready;
    logic       m_valid;
    logic       cfg_ready;
    rsp_t       m_data;

    int fails;
    int due;
    int checked;

    // Stimulus knobs, changed per phase.
    bit idle_on     = 1'b1;
    bit quiet       = 1'b0;
    int last_pct    = 15;
    int clear_pct   = 5;
    int regrant_pct = 20;

    // Light shadow of the table, only to steer requests away from a halt
    // until the very end and toward hits. Pins are unique in the table.
    bit         held   [256];
    logic [4:0] own_of [256];
    bit         sh_of  [256];
    logic [7:0] tbl_pins [DEPTH];
    int         fill_g    = 0;
    int         cur_limit = 32;

    int sent   = 0;
    int writes = 0;

    pin_ownership_claim_table_core #(
        .MAX_ENTRIES(DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    poct_claim_checker #(
        .TABLE_DEPTH(DEPTH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (fails),
        .outstanding (due),
        .answered    (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: hold m_ready low in random bursts, none when quiet or idle_on is off.
    always @(posedge aclk) begin
        int stall_left;
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic req_t mk(input logic [1:0] act, input logic [7:0] pin,
                                input logic [4:0] owner, input logic crit,
                                input logic shr, input logic last);
        req_t r;
        r.action     = act;
        r.pin        = pin;
        r.owner      = owner;
        r.critical   = crit;
        r.shared     = shr;
        r.batch_last = last;
        return r;
    endfunction

    // Mirror the table effect of a request in the shadow.
    task automatic track(input req_t r);
        if (r.action == ACT_CLEAR) begin
            held   = '{default: 1'b0};
            fill_g = 0;
        end else if (r.action == ACT_CLAIM && r.pin != PIN_EMPTY && !held[r.pin]
                     && fill_g < cur_limit) begin
            held[r.pin]      = 1'b1;
            own_of[r.pin]    = r.owner;
            sh_of[r.pin]     = r.shared;
            tbl_pins[fill_g] = r.pin;
            fill_g++;
        end
    endtask

    // Send one request; optionally drop valid for an idle burst first.
    // Valid is otherwise held high from one request to the next.
    task automatic issue(input req_t r);
        int gap;
        gap = (idle_on && !quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
        track(r);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    // Drop valid and wait until every owed response has been taken.
    task automatic drain_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the table limit; only ever done with the block idle.
    task automatic write_limit(input logic [5:0] v);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_limit = (v > 6'(DEPTH)) ? DEPTH : int'(v);
        writes++;
    endtask

    // Build one random request. Claims lean toward table hits and shared
    // re-grants; a claim that would hit without a grant is never critical and
    // a new pin is only offered while the table has room, so no halt occurs.
    task automatic pick_req(output req_t r);
        int         roll;
        int         k;
        logic [7:0] p;
        bit         hit;
        bit         grantable;
        r.action     = ACT_CLAIM;
        r.owner      = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(20, 31))
                                                   : 5'($urandom_range(0, 19));
        r.critical   = 1'($urandom_range(0, 1));
        r.shared     = ($urandom_range(0, 3) != 0);
        r.batch_last = ($urandom_range(0, 99) < last_pct);
        r.pin        = 8'($urandom_range(0, 255));
        roll         = $urandom_range(0, 99);
        if (roll < clear_pct) begin
            r.action = ACT_CLEAR;
        end else if (roll < clear_pct + 12) begin
            r.action = ACT_QUERY;
            if (fill_g > 0 && $urandom_range(0, 3) != 0)
                r.pin = tbl_pins[$urandom_range(0, fill_g - 1)];
        end else if (roll < clear_pct + 24) begin
            r.action = ACT_RESOLVE;
            if (fill_g > 0 && $urandom_range(0, 3) != 0) begin
                r.pin = tbl_pins[$urandom_range(0, fill_g - 1)];
                if ($urandom_range(0, 2) != 0) r.owner = own_of[r.pin];
            end
        end else if (roll < clear_pct + 28) begin
            r.pin = PIN_EMPTY;
        end else begin
            if (fill_g > 0 && $urandom_range(0, 99) < regrant_pct) begin
                // prefer a shared entry so the re-claim is granted
                k = $urandom_range(0, fill_g - 1);
                for (int t = 0; t < 4 && !sh_of[tbl_pins[k]]; t++)
                    k = $urandom_range(0, fill_g - 1);
                r.pin    = tbl_pins[k];
                r.owner  = own_of[r.pin];
                r.shared = 1'b1;
            end else if (fill_g > 0 && ($urandom_range(0, 2) == 0 || fill_g >= cur_limit)) begin
                r.pin = tbl_pins[$urandom_range(0, fill_g - 1)];
            end else if (fill_g < cur_limit) begin
                do p = 8'($urandom_range(0, 254)); while (held[p]);
                r.pin = p;
            end else begin
                r.pin = PIN_EMPTY;
            end
            hit       = held[r.pin];
            grantable = hit && r.owner == own_of[r.pin] && sh_of[r.pin] && r.shared;
            if (hit && !grantable) r.critical = 1'b0;
        end
    endtask

    task automatic run_phase(input int n, input logic [5:0] lim, input int lp,
                             input int cp, input int rp);
        req_t r;
        write_limit(lim);
        last_pct    = lp;
        clear_pct   = cp;
        regrant_pct = rp;
        idle_on     = ($urandom_range(0, 3) != 0);
        repeat (n) begin
            pick_req(r);
            issue(r);
        end
    endtask

    initial begin
        req_t  r;
        bit    end_on_conflict;
        string end_kind;
        held = '{default: 1'b0};

        // Hold reset low from the start, then release it for good.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, skip, new/shared grant, rejects, queries,
        // resolves, batch end on new, skipped and rejected claims, clear with batch end set.
        issue(mk(ACT_QUERY,   8'd0,      5'd0,  1'b0, 1'b0, 1'b0));
        issue(mk(ACT_RESOLVE, PIN_EMPTY, 5'd0,  1'b0, 1'b0, 1'b0));
        issue(mk(ACT_CLAIM,   PIN_EMPTY, 5'd31, 1'b1, 1'b1, 1'b0));
        issue(mk(ACT_CLAIM,   8'd0,      5'd0,  1'b0, 1'b1, 1'b0));
        issue(mk(ACT_CLAIM,   8'd0,      5'd0,  1'b1, 1'b1, 1'b0));
        issue(mk(ACT_CLAIM,   8'd0,      5'd0,  1'b0, 1'b0, 1'b0));
        issue(mk(ACT_CLAIM,   8'd0,      5'd31, 1'b0, 1'b1, 1'b0));
        issue(mk(ACT_CLAIM,   8'd254,    5'd31, 1'b1, 1'b0, 1'b0));
        issue(mk(ACT_CLAIM,   8'd254,    5'd31, 1'b0, 1'b1, 1'b0));
        issue(mk(ACT_QUERY,   8'd254,    5'd0,  1'b1, 1'b1, 1'b1));
        issue(mk(ACT_RESOLVE, 8'd254,    5'd31, 1'b0, 1'b0, 1'b0));
        issue(mk(ACT_RESOLVE, 8'd254,    5'd30, 1'b0, 1'b0, 1'b0));
        issue(mk(ACT_CLAIM,   8'd128,    5'd19, 1'b0, 1'b1, 1'b1));
        issue(mk(ACT_CLAIM,   8'd1,      5'd20, 1'b0, 1'b1, 1'b0));
        issue(mk(ACT_CLAIM,   PIN_EMPTY, 5'd0,  1'b0, 1'b0, 1'b1));
        issue(mk(ACT_CLAIM,   8'd1,      5'd20, 1'b0, 1'b1, 1'b0));
        issue(mk(ACT_CLAIM,   8'd0,      5'd5,  1'b0, 1'b0, 1'b1));
        issue(mk(ACT_CLEAR,   PIN_EMPTY, 5'd31, 1'b1, 1'b1, 1'b1));
        issue(mk(ACT_QUERY,   8'd0,      5'd0,  1'b0, 1'b0, 1'b0));
        issue(mk(ACT_CLAIM,   8'd0,      5'd1,  1'b0, 1'b0, 1'b0));
        issue(mk(ACT_QUERY,   PIN_EMPTY, 5'd31, 1'b0, 1'b0, 1'b0));
        issue(mk(ACT_RESOLVE, 8'd0,      5'd1,  1'b1, 1'b1, 1'b1));

        // Random phases over limits that include 0, 1, the top value and
        // values below the current fill. Each limit write drains first, which
        // also gives the sender full pauses.
        run_phase(160, 6'd8,  15, 5, 20);
        run_phase(120, 6'd1,  15, 6, 20);
        run_phase(160, 6'd63, 10, 3, 25);
        run_phase(100, 6'd0,  15, 4, 30);
        run_phase(160, 6'd3,  15, 5, 20);
        // one long batch: drive the grant count into saturation
        run_phase(500, 6'd32, 0,  2, 90);
        run_phase(150, 6'd17, 20, 5, 20);
        run_phase(100, 6'd2,  25, 8, 20);
        quiet = 1'b1;
        run_phase(150, 6'd32, 15, 5, 20);

        // End on the sticky halt; only one kind can be seen per run.
        end_on_conflict = 1'($urandom_range(0, 1));
        issue(mk(ACT_CLEAR, 8'd0, 5'd0, 1'b0, 1'b0, 1'b0));
        if (end_on_conflict) begin
            end_kind = "conflict";
            issue(mk(ACT_CLAIM, 8'd77, 5'd3, 1'b0, 1'b0, 1'b0));
            issue(mk(ACT_CLAIM, 8'd77, 5'd4, 1'b1, 1'b1, 1'b0));
        end else begin
            end_kind = "full table";
            write_limit(6'd0);
            issue(mk(ACT_CLAIM, 8'd200, 5'd5, 1'b0, 1'b1, 1'b0));
        end
        // Every action after the halt, clear included, must answer halted.
        for (int i = 0; i < 12; i++) begin
            r            = req_t'($urandom);
            r.action     = 2'(i);
            r.batch_last = 1'b1;
            issue(r);
        end

        drain_block();
        repeat (40) @(posedge aclk);

        $display("Sent %0d requests across %0d limit writes, %0d responses checked",
                 sent, writes, checked);
        $display("Covered grants, rejects, skips, batch saturation and a %s halt", end_kind);
        if (fails == 0 && due == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
